[rtl/core/dcsp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcsp_pkg: shared types and constants of the depth column splat projector
// Payload structs of both channels, register indexes and reset values.
// ----------------------------------------------------------------------------
package dcsp_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int POS_W      = 11;   // column / row fields of a result
  localparam int FRAC_W     = 14;   // Q.14 camera coordinates
  localparam int DEPTH_SHIFT = 6;   // Q8.8 scale times depth step into Q.14

  localparam logic signed [8:0] DEPTH_BIAS = 9'sd128;

  // reset values of the configuration registers
  localparam int                   RST_IMAGE_SIZE  = 2048;
  localparam logic [1:0]           RST_SCAN_DIR    = 2'd3;
  localparam logic signed [15:0]   RST_CAM_UNIT    = 16'sd16384;
  localparam logic signed [15:0]   RST_CAM_ZERO    = 16'sd0;
  localparam logic [15:0]          RST_DEPTH_SCALE = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH    = 3'd0,
    CFG_IMAGE_HEIGHT   = 3'd1,
    CFG_SCAN_DIRECTION = 3'd2,
    CFG_CAMX_X         = 3'd3,
    CFG_CAMX_Y         = 3'd4,
    CFG_CAMY_X         = 3'd5,
    CFG_CAMY_Y         = 3'd6,
    CFG_DEPTH_SCALE    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] depth;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row_first;
    logic [POS_W-1:0] row_last;
    logic [7:0]       out_blue;
    logic [7:0]       out_green;
    logic [7:0]       out_red;
  } out_item_t;

endpackage

[rtl/core/depth_column_splat_projector_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_column_splat_projector_top: depth pixel to painted column span
// Tracks scan position and neighbor depths, projects each pixel into camera
// space and emits the clipped vertical span to paint, or nothing.
// ----------------------------------------------------------------------------
//  channel | ports                              | moves
//  --------+------------------------------------+-----------------------------
//  in      | in_valid, in_stall, in_data        | one depth + color pixel
//  out     | out_valid, out_stall, out_data     | one span (zero or one/pixel)
//  cfg     | cfg_wr_en, cfg_index, cfg_wdata    | one register write
//
//  One pixel per cycle while in_stall is low. A pixel is registered at the
//  input register (projection of the scan position), then its result at the
//  output register (depth span and clipping); the line memory read is issued
//  at the input transaction. Synchronous reset; the line memory is not
//  cleared. in_stall rises only when stage one holds a pixel and a stalled
//  result occupies the output register.
// ----------------------------------------------------------------------------
module depth_column_splat_projector_top #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  dcsp_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output dcsp_pkg::out_item_t                  out_data,
  input  logic                                 cfg_wr_en,
  input  dcsp_pkg::cfg_idx_t                   cfg_index,
  input  logic [dcsp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int OW = ((XW > YW) ? XW : YW) + 1;
  localparam int PW = OW + 18;
  localparam int LW = ((PW > 31) ? PW : 31) + 1;
  localparam int FW = dcsp_pkg::FRAC_W;
  localparam int QW = dcsp_pkg::POS_W;
  localparam int W_RST = (MAX_WIDTH < dcsp_pkg::RST_IMAGE_SIZE) ?
                         MAX_WIDTH : dcsp_pkg::RST_IMAGE_SIZE;
  localparam int H_RST = (MAX_HEIGHT < dcsp_pkg::RST_IMAGE_SIZE) ?
                         MAX_HEIGHT : dcsp_pkg::RST_IMAGE_SIZE;

  // configuration
  logic [WW-1:0]        w_eff_r, w_eff_nxt;
  logic [HW-1:0]        h_eff_r, h_eff_nxt;
  logic [1:0]           dir_r, dir_nxt;
  logic signed [15:0]   camx_x_r, camx_y_r, camy_x_r, camy_y_r;
  logic [15:0]          ds_r;
  logic                 restart;

  // scan position and neighbor state
  logic [XW-1:0]        col_cnt_r, col_nxt;
  logic [YW-1:0]        row_cnt_r, row_nxt;
  logic [7:0]           left_r, upl_r;
  logic [7:0]           line_mem [MAX_WIDTH];
  logic [7:0]           line_rd_r;

  // stage one
  logic                 s1_valid_r;
  dcsp_pkg::in_item_t   s1_item_r;
  logic signed [PW-1:0] s1_camy_r;
  logic                 s1_col_ok_r;
  logic [QW-1:0]        s1_column_r;
  logic                 s1_first_col_r, s1_first_row_r;

  // output register
  logic                 out_valid_r;
  dcsp_pkg::out_item_t  out_r;

  logic                 in_acc, s1_adv;

  // ---------------------------------------------------------------- config
  always_comb begin
    w_eff_nxt = w_eff_r;
    h_eff_nxt = h_eff_r;
    dir_nxt   = dir_r;
    restart   = 1'b0;
    if (cfg_wr_en) begin
      case (cfg_index)
        dcsp_pkg::CFG_IMAGE_WIDTH: begin
          restart = 1'b1;
          if (cfg_wdata[11:0] < 12'd2) begin
            w_eff_nxt = WW'(2);
          end else if (32'(cfg_wdata[11:0]) > 32'(MAX_WIDTH)) begin
            w_eff_nxt = WW'(MAX_WIDTH);
          end else begin
            w_eff_nxt = WW'(cfg_wdata[11:0]);
          end
        end
        dcsp_pkg::CFG_IMAGE_HEIGHT: begin
          restart = 1'b1;
          if (cfg_wdata[11:0] < 12'd2) begin
            h_eff_nxt = HW'(2);
          end else if (32'(cfg_wdata[11:0]) > 32'(MAX_HEIGHT)) begin
            h_eff_nxt = HW'(MAX_HEIGHT);
          end else begin
            h_eff_nxt = HW'(cfg_wdata[11:0]);
          end
        end
        dcsp_pkg::CFG_SCAN_DIRECTION: begin
          restart = 1'b1;
          dir_nxt = cfg_wdata[1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r  <= WW'(W_RST);
      h_eff_r  <= HW'(H_RST);
      dir_r    <= dcsp_pkg::RST_SCAN_DIR;
      camx_x_r <= dcsp_pkg::RST_CAM_UNIT;
      camx_y_r <= dcsp_pkg::RST_CAM_ZERO;
      camy_x_r <= dcsp_pkg::RST_CAM_ZERO;
      camy_y_r <= dcsp_pkg::RST_CAM_UNIT;
      ds_r     <= dcsp_pkg::RST_DEPTH_SCALE;
    end else begin
      w_eff_r <= w_eff_nxt;
      h_eff_r <= h_eff_nxt;
      dir_r   <= dir_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          dcsp_pkg::CFG_CAMX_X:      camx_x_r <= cfg_wdata;
          dcsp_pkg::CFG_CAMX_Y:      camx_y_r <= cfg_wdata;
          dcsp_pkg::CFG_CAMY_X:      camy_x_r <= cfg_wdata;
          dcsp_pkg::CFG_CAMY_Y:      camy_y_r <= cfg_wdata;
          dcsp_pkg::CFG_DEPTH_SCALE: ds_r     <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // ------------------------------------------------------- scan position
  logic [WW-1:0] w_m1;
  logic [HW-1:0] h_m1;
  logic [XW-1:0] x_cl, col_start, col_start_nxt;
  logic [YW-1:0] y_cl, row_start, row_start_nxt;
  logic          col_end, row_end;

  always_comb begin
    w_m1          = w_eff_r - WW'(1);
    h_m1          = h_eff_r - HW'(1);
    x_cl          = (WW'(col_cnt_r) >= w_eff_r) ? XW'(w_m1) : col_cnt_r;
    y_cl          = (HW'(row_cnt_r) >= h_eff_r) ? YW'(h_m1) : row_cnt_r;
    col_start     = dir_r[0] ? XW'(w_m1) : '0;
    row_start     = dir_r[1] ? YW'(h_m1) : '0;
    col_start_nxt = dir_nxt[0] ? XW'(w_eff_nxt - WW'(1)) : '0;
    row_start_nxt = dir_nxt[1] ? YW'(h_eff_nxt - HW'(1)) : '0;
    col_end       = dir_r[0] ? (x_cl == '0) : (x_cl == XW'(w_m1));
    row_end       = dir_r[1] ? (y_cl == '0) : (y_cl == YW'(h_m1));

    col_nxt = col_cnt_r;
    row_nxt = row_cnt_r;
    if (restart) begin
      col_nxt = col_start_nxt;
      row_nxt = row_start_nxt;
    end else if (in_acc) begin
      if (!col_end) begin
        col_nxt = dir_r[0] ? x_cl - XW'(1) : x_cl + XW'(1);
        row_nxt = y_cl;
      end else begin
        col_nxt = col_start;
        if (row_end) begin
          row_nxt = row_start;
        end else begin
          row_nxt = dir_r[1] ? y_cl - YW'(1) : y_cl + YW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= XW'(W_RST - 1);
      row_cnt_r <= YW'(H_RST - 1);
    end else begin
      col_cnt_r <= col_nxt;
      row_cnt_r <= row_nxt;
    end
  end

  // previous-row line: read old value and write the new depth at the same edge
  always_ff @(posedge clk) begin
    if (in_acc) begin
      line_rd_r       <= line_mem[x_cl];
      line_mem[x_cl]  <= in_data.depth;
    end
  end

  // ------------------------------------------------- projection of position
  logic signed [OW-1:0]    ox, oy;
  logic signed [OW+15:0]   p_xx, p_xy, p_yx, p_yy;
  logic signed [PW-1:0]    camx, camy, col_lim;

  always_comb begin
    ox      = OW'(x_cl) - OW'(w_eff_r[WW-1:1]);
    oy      = OW'(y_cl) - OW'(h_eff_r[HW-1:1]);
    p_xx    = camx_x_r * ox;
    p_xy    = camx_y_r * oy;
    p_yx    = camy_x_r * ox;
    p_yy    = camy_y_r * oy;
    camx    = (PW'(w_eff_r[WW-1:1]) << FW) - (PW'(p_xx) + PW'(p_xy));
    camy    = (PW'(h_eff_r[HW-1:1]) << FW) - (PW'(p_yx) + PW'(p_yy));
    col_lim = PW'({w_m1, {FW{1'b0}}});
  end

  // ------------------------------------------------------------ handshake
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r      <= in_data;
      s1_camy_r      <= camy;
      s1_col_ok_r    <= (camx >= 0) && (camx < col_lim);
      s1_column_r    <= camx[FW +: QW];
      s1_first_col_r <= (x_cl == col_start);
      s1_first_row_r <= (y_cl == row_start);
    end
  end

  // left and upper-left follow the pixel leaving stage one
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      left_r <= '0;
      upl_r  <= '0;
    end else if (s1_adv) begin
      left_r <= s1_item_r.depth;
      upl_r  <= line_rd_r;
    end
  end

  // ------------------------------------------------------ depth span, clip
  logic [7:0]              up, left, upleft, back;
  logic signed [8:0]       back_c, depth_c;
  logic signed [24:0]      dz_back, dz_depth;
  logic signed [LW-1:0]    lo, hi, hlim;
  logic                    res_ok;
  dcsp_pkg::out_item_t     res;

  always_comb begin
    up     = s1_first_row_r ? s1_item_r.depth : line_rd_r;
    left   = s1_first_col_r ? s1_item_r.depth : left_r;
    upleft = s1_first_col_r ? line_rd_r : upl_r;
    if (s1_first_row_r) begin
      upleft = left;
    end
    back = s1_item_r.depth;
    if (up > back)     back = up;
    if (left > back)   back = left;
    if (upleft > back) back = upleft;

    back_c   = $signed({1'b0, back}) - dcsp_pkg::DEPTH_BIAS;
    depth_c  = $signed({1'b0, s1_item_r.depth}) - dcsp_pkg::DEPTH_BIAS;
    dz_back  = $signed({1'b0, ds_r}) * back_c;
    dz_depth = $signed({1'b0, ds_r}) * depth_c;
    lo   = LW'(s1_camy_r) - (LW'(dz_back) <<< dcsp_pkg::DEPTH_SHIFT);
    hi   = LW'(s1_camy_r) - (LW'(dz_depth) <<< dcsp_pkg::DEPTH_SHIFT);
    hlim = LW'({h_eff_r, {FW{1'b0}}});

    res_ok        = s1_col_ok_r && (hi > 0) && (lo < hlim);
    res.column    = s1_column_r;
    res.row_first = (lo <= 0) ? '0 : lo[FW +: QW];
    res.row_last  = (hi >= hlim) ? QW'(h_m1) : hi[FW +: QW];
    res.out_blue  = s1_item_r.blue;
    res.out_green = s1_item_r.green;
    res.out_red   = s1_item_r.red;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= res_ok;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ------------------------------------------------------------ assertions
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked stage-one pixel");

  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (WW'(col_cnt_r) < w_eff_r) && (HW'(row_cnt_r) < h_eff_r))
    else $error("scan position outside the image");

  a_restart_pos: assert property (@(posedge clk) disable iff (!rst_n)
    restart |=> (col_cnt_r == col_start) && (row_cnt_r == row_start))
    else $error("frame restart did not return to the scan start");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> s1_valid_r && $stable(s1_item_r)
                                 && $stable(s1_camy_r))
    else $error("blocked stage-one pixel changed");

endmodule

[test/tb_depth_column_splat_projector_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_depth_column_splat_projector_top: self-checking bench for the splat
// projector
// A clocked driver feeds pixels and register writes from a queue that the
// stimulus block fills. Each accepted pixel runs through a local scan and
// projection model, and any span it produces is queued. A clocked monitor
// compares every accepted span with the oldest queued one. Both sides idle
// at random, and a watchdog ends a run that stops moving.
// ----------------------------------------------------------------------------
module tb_depth_column_splat_projector_top;

  localparam int MAX_W          = 2048;
  localparam int MAX_H          = 2048;
  localparam int RANDOM_PIXELS  = 1350;
  localparam int DRAIN_CYCLES   = 4;
  localparam int TAIL_CYCLES    = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 120;

  typedef struct {
    bit                 is_write;
    dcsp_pkg::cfg_idx_t reg_idx;
    logic [15:0]        reg_val;
    dcsp_pkg::in_item_t px;
  } feed_entry_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  dcsp_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  dcsp_pkg::out_item_t out_data;
  logic                cfg_wr_en = 1'b0;
  dcsp_pkg::cfg_idx_t  cfg_index = dcsp_pkg::CFG_IMAGE_WIDTH;
  logic [15:0]         cfg_wdata = '0;

  depth_column_splat_projector_top #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // scan and projection model
  // --------------------------------------------------------------------------
  logic [11:0]        img_width, img_height;
  logic [1:0]         scan_dir;
  logic signed [15:0] camx_x_q, camx_y_q, camy_x_q, camy_y_q;
  logic [15:0]        depth_scale_q;

  logic [7:0] line_depth [MAX_W];
  logic [7:0] left_d, upleft_d;
  int         col_pos, row_pos;

  function automatic int eff_size(logic [11:0] v, int maxv);
    if (v < 2) return 2;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic int col_origin();
    return scan_dir[0] ? eff_size(img_width, MAX_W) - 1 : 0;
  endfunction

  function automatic int row_origin();
    return scan_dir[1] ? eff_size(img_height, MAX_H) - 1 : 0;
  endfunction

  function automatic void restart_scan();
    col_pos  = col_origin();
    row_pos  = row_origin();
    left_d   = '0;
    upleft_d = '0;
  endfunction

  function automatic void write_register(dcsp_pkg::cfg_idx_t idx, logic [15:0] v);
    case (idx)
      dcsp_pkg::CFG_IMAGE_WIDTH: begin
        img_width = v[11:0];
        restart_scan();
      end
      dcsp_pkg::CFG_IMAGE_HEIGHT: begin
        img_height = v[11:0];
        restart_scan();
      end
      dcsp_pkg::CFG_SCAN_DIRECTION: begin
        scan_dir = v[1:0];
        restart_scan();
      end
      dcsp_pkg::CFG_CAMX_X:      camx_x_q = v;
      dcsp_pkg::CFG_CAMX_Y:      camx_y_q = v;
      dcsp_pkg::CFG_CAMY_X:      camy_x_q = v;
      dcsp_pkg::CFG_CAMY_Y:      camy_y_q = v;
      dcsp_pkg::CFG_DEPTH_SCALE: depth_scale_q = v;
      default: ;
    endcase
  endfunction

  function automatic void model_reset();
    img_width     = 12'(dcsp_pkg::RST_IMAGE_SIZE);
    img_height    = 12'(dcsp_pkg::RST_IMAGE_SIZE);
    scan_dir      = dcsp_pkg::RST_SCAN_DIR;
    camx_x_q      = dcsp_pkg::RST_CAM_UNIT;
    camx_y_q      = dcsp_pkg::RST_CAM_ZERO;
    camy_x_q      = dcsp_pkg::RST_CAM_ZERO;
    camy_y_q      = dcsp_pkg::RST_CAM_UNIT;
    depth_scale_q = dcsp_pkg::RST_DEPTH_SCALE;
    for (int i = 0; i < MAX_W; i++) line_depth[i] = '0;
    restart_scan();
  endfunction

  // Returns 1 when the pixel paints a span; advances the scan either way.
  function automatic bit project_span(input dcsp_pkg::in_item_t px,
                                      output dcsp_pkg::out_item_t span);
    int         w, h, x, y;
    bit         first_col, first_row, col_end, row_end, hit;
    logic [7:0] d, up, upl, lft, back, m1, m2;
    longint     ox, oy, camx, camy, lo, hi, hlim, t;
    w = eff_size(img_width, MAX_W);
    h = eff_size(img_height, MAX_H);
    x = (col_pos >= w) ? w - 1 : col_pos;
    y = (row_pos >= h) ? h - 1 : row_pos;
    d = px.depth;
    first_col = (x == col_origin());
    first_row = (y == row_origin());

    up  = line_depth[x];
    lft = first_col ? d : left_d;
    upl = first_col ? up : upleft_d;
    if (first_row) begin
      upl = lft;
      up  = d;
    end
    m1 = (d > up) ? d : up;
    m2 = (upl > lft) ? upl : lft;
    back = (m1 > m2) ? m1 : m2;

    ox   = longint'(x) - longint'(w / 2);
    oy   = longint'(y) - longint'(h / 2);
    camx = longint'(w / 2) * 16384 - (longint'(camx_x_q) * ox + longint'(camx_y_q) * oy);
    camy = longint'(h / 2) * 16384 - (longint'(camy_x_q) * ox + longint'(camy_y_q) * oy);
    lo   = camy - longint'(depth_scale_q) * (longint'(back) - 128) * 64;
    hi   = camy - longint'(depth_scale_q) * (longint'(d) - 128) * 64;
    hlim = longint'(h) * 16384;

    span = '0;
    hit = (camx >= 0) && (camx < longint'(w - 1) * 16384) && (hi > 0) && (lo < hlim);
    if (hit) begin
      t = camx >>> dcsp_pkg::FRAC_W;
      span.column = t[dcsp_pkg::POS_W-1:0];
      t = (lo <= 0) ? 0 : (lo >>> dcsp_pkg::FRAC_W);
      span.row_first = t[dcsp_pkg::POS_W-1:0];
      t = (hi >= hlim) ? longint'(h - 1) : (hi >>> dcsp_pkg::FRAC_W);
      span.row_last  = t[dcsp_pkg::POS_W-1:0];
      span.out_blue  = px.blue;
      span.out_green = px.green;
      span.out_red   = px.red;
    end

    upleft_d      = line_depth[x];
    line_depth[x] = d;
    left_d        = d;

    col_end = scan_dir[0] ? (x == 0) : (x >= w - 1);
    row_end = scan_dir[1] ? (y == 0) : (y >= h - 1);
    if (!col_end) begin
      col_pos = scan_dir[0] ? x - 1 : x + 1;
      row_pos = y;
    end else begin
      col_pos = col_origin();
      if (!row_end) row_pos = scan_dir[1] ? y - 1 : y + 1;
      else          row_pos = row_origin();
    end
    return hit;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  feed_entry_t         pixel_feed [$];
  dcsp_pkg::out_item_t span_expect_q [$];
  int                  fail_count = 0;

  function automatic void push_pixel(logic [7:0] d, logic [7:0] b, logic [7:0] g,
                                     logic [7:0] r);
    feed_entry_t e;
    e.is_write = 1'b0;
    e.reg_idx  = dcsp_pkg::CFG_IMAGE_WIDTH;
    e.reg_val  = '0;
    e.px       = '{depth: d, blue: b, green: g, red: r};
    pixel_feed.insert(pixel_feed.size(), e);
  endfunction

  function automatic void push_write(dcsp_pkg::cfg_idx_t idx, logic [15:0] v);
    feed_entry_t e;
    e.is_write = 1'b1;
    e.reg_idx  = idx;
    e.reg_val  = v;
    e.px       = '0;
    pixel_feed.insert(pixel_feed.size(), e);
  endfunction

  function automatic void push_random_pixel();
    logic [7:0] d;
    case ($urandom_range(0, 7))
      0:       d = 8'd0;
      1:       d = 8'd255;
      default: d = 8'($urandom_range(0, 255));
    endcase
    push_pixel(d, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)));
  endfunction

  // main camera axis near unit length, either sign
  function automatic logic [15:0] axis_gain();
    int g;
    g = int'($urandom_range(12000, 16384));
    return $urandom_range(0, 1) ? 16'(g) : 16'(-g);
  endfunction

  function automatic logic [15:0] cross_gain();
    int g;
    g = int'($urandom_range(0, 4000)) - 2000;
    return 16'(g);
  endfunction

  function automatic logic [15:0] random_size();
    case ($urandom_range(0, 15))
      0:       return 16'($urandom_range(0, 1));
      1:       return 16'($urandom_range(2049, 4095));
      2:       return 16'd2048;
      3:       return 16'($urandom_range(0, 65535));   // upper bits ignored
      default: return 16'($urandom_range(2, 16));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // driver
  // --------------------------------------------------------------------------
  int                  tx_gap = 0;
  int                  quiet = 0;
  bit                  tx_burst = 1'b0;
  bit                  offer, wr_now;
  feed_entry_t         head;
  dcsp_pkg::out_item_t predicted;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      cfg_wr_en <= 1'b0;
      tx_gap = 0;
      quiet  = 0;
    end else begin
      offer  = in_valid && in_stall;
      wr_now = 1'b0;
      if (in_valid && !in_stall) begin
        if (project_span(in_data, predicted)) begin
          span_expect_q.insert(span_expect_q.size(), predicted);
        end
        quiet  = 0;
        tx_gap = tx_burst ? 0 : int'($urandom_range(0, 9));
        if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
      end else if (!in_valid) begin
        quiet++;
      end
      if (!offer) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pixel_feed.size() > 0) begin
          if (!pixel_feed[0].is_write) begin
            head = pixel_feed.pop_front();
            in_data <= head.px;
            offer = 1'b1;
          end else if (span_expect_q.size() == 0 && quiet >= DRAIN_CYCLES) begin
            // block is idle: nothing owed, pipeline drained
            head = pixel_feed.pop_front();
            cfg_index <= head.reg_idx;
            cfg_wdata <= head.reg_val;
            write_register(head.reg_idx, head.reg_val);
            wr_now = 1'b1;
          end
        end
      end
      in_valid  <= offer;
      cfg_wr_en <= wr_now;
    end
  end

  // --------------------------------------------------------------------------
  // monitor
  // --------------------------------------------------------------------------
  int                  rx_wait = 0;
  int                  rx_hold = 0;
  int                  spans_seen = 0;
  bit                  rx_burst = 1'b0;
  dcsp_pkg::out_item_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
      rx_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        spans_seen++;
        if (span_expect_q.size() == 0) begin
          $error("unexpected span transaction: column %0d rows %0d..%0d",
                 out_data.column, out_data.row_first, out_data.row_last);
          fail_count++;
        end else begin
          want = span_expect_q.pop_front();
          if (out_data.column !== want.column) begin
            $error("column: expected %0d, got %0d", want.column, out_data.column);
            fail_count++;
          end
          if (out_data.row_first !== want.row_first) begin
            $error("row_first: expected %0d, got %0d", want.row_first, out_data.row_first);
            fail_count++;
          end
          if (out_data.row_last !== want.row_last) begin
            $error("row_last: expected %0d, got %0d", want.row_last, out_data.row_last);
            fail_count++;
          end
          if (out_data.out_blue !== want.out_blue) begin
            $error("out_blue: expected %0d, got %0d", want.out_blue, out_data.out_blue);
            fail_count++;
          end
          if (out_data.out_green !== want.out_green) begin
            $error("out_green: expected %0d, got %0d", want.out_green, out_data.out_green);
            fail_count++;
          end
          if (out_data.out_red !== want.out_red) begin
            $error("out_red: expected %0d, got %0d", want.out_red, out_data.out_red);
            fail_count++;
          end
        end
        rx_wait = rx_burst ? 0 : int'($urandom_range(0, 9));
        if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
        // long back-pressure so the pipeline fills and stalls the input
        if (spans_seen == 30 || spans_seen == 300) rx_hold = LONG_HOLD;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      if (rx_hold > 0) rx_hold--;
      out_stall <= (rx_wait > 0) || (rx_hold > 0);
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: cycles with no transaction on any port
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int  sent;
    int  n;
    int  mode;
    bit  resize;
    model_reset();

    // reset setup: reverse scan starts at the last column and last row
    push_pixel(8'd0,   8'd0,   8'd0,   8'd0);
    push_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    push_pixel(8'd128, 8'hAA,  8'h55,  8'hAA);

    // undersized image acts as 2x2; forward scan, full frame plus a wrap
    push_write(dcsp_pkg::CFG_IMAGE_WIDTH, 16'd0);
    push_write(dcsp_pkg::CFG_IMAGE_HEIGHT, 16'd1);
    push_write(dcsp_pkg::CFG_SCAN_DIRECTION, 16'd0);
    push_write(dcsp_pkg::CFG_DEPTH_SCALE, 16'd16);
    push_pixel(8'd10,  8'h55,  8'hAA,  8'h55);
    push_pixel(8'd200, 8'd1,   8'd2,   8'd3);
    push_pixel(8'd50,  8'd4,   8'd5,   8'd6);
    push_pixel(8'd0,   8'd7,   8'd8,   8'd9);
    push_pixel(8'd255, 8'd10,  8'd11,  8'd12);
    push_pixel(8'd128, 8'd13,  8'd14,  8'd15);

    // 3x3, columns descend, camera axes at their extremes, zero depth scale
    push_write(dcsp_pkg::CFG_IMAGE_WIDTH, 16'd3);
    push_write(dcsp_pkg::CFG_IMAGE_HEIGHT, 16'd3);
    push_write(dcsp_pkg::CFG_SCAN_DIRECTION, 16'd1);
    push_write(dcsp_pkg::CFG_CAMX_X, 16'(-16384));
    push_write(dcsp_pkg::CFG_CAMX_Y, 16'd16384);
    push_write(dcsp_pkg::CFG_CAMY_X, 16'd16384);
    push_write(dcsp_pkg::CFG_CAMY_Y, 16'(-16384));
    push_write(dcsp_pkg::CFG_DEPTH_SCALE, 16'd0);
    for (int i = 0; i < 9; i++) push_pixel(8'(i * 31), 8'(i), 8'(255 - i), 8'(i * 17));

    // oversized width acts as the maximum, rows descend, largest depth scale
    push_write(dcsp_pkg::CFG_IMAGE_WIDTH, 16'hFFFF);
    push_write(dcsp_pkg::CFG_IMAGE_HEIGHT, 16'd3);
    push_write(dcsp_pkg::CFG_SCAN_DIRECTION, 16'd2);
    push_write(dcsp_pkg::CFG_CAMX_X, 16'd16384);
    push_write(dcsp_pkg::CFG_CAMX_Y, 16'd0);
    push_write(dcsp_pkg::CFG_CAMY_X, 16'd0);
    push_write(dcsp_pkg::CFG_CAMY_Y, 16'd16384);
    push_write(dcsp_pkg::CFG_DEPTH_SCALE, 16'hFFFF);
    push_pixel(8'd0,   8'd255, 8'd0,   8'd255);
    push_pixel(8'd255, 8'd0,   8'd255, 8'd0);
    push_pixel(8'd127, 8'd128, 8'd127, 8'd128);
    push_pixel(8'd129, 8'd64,  8'd32,  8'd16);

    // random phases; most keep the projection inside a small image
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      mode   = int'($urandom_range(0, 9));
      resize = ($urandom_range(0, 3) != 0);
      if (resize) begin
        push_write(dcsp_pkg::CFG_IMAGE_WIDTH, random_size());
        push_write(dcsp_pkg::CFG_IMAGE_HEIGHT, random_size());
        push_write(dcsp_pkg::CFG_SCAN_DIRECTION, 16'($urandom_range(0, 3)));
      end
      if (mode < 7) begin
        push_write(dcsp_pkg::CFG_CAMX_X, axis_gain());
        push_write(dcsp_pkg::CFG_CAMX_Y, cross_gain());
        push_write(dcsp_pkg::CFG_CAMY_X, cross_gain());
        push_write(dcsp_pkg::CFG_CAMY_Y, axis_gain());
        push_write(dcsp_pkg::CFG_DEPTH_SCALE,
                   ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 32)));
      end else begin
        push_write(dcsp_pkg::CFG_CAMX_X, 16'($urandom_range(0, 65535)));
        push_write(dcsp_pkg::CFG_CAMX_Y, 16'($urandom_range(0, 65535)));
        push_write(dcsp_pkg::CFG_CAMY_X, 16'($urandom_range(0, 65535)));
        push_write(dcsp_pkg::CFG_CAMY_Y, 16'($urandom_range(0, 65535)));
        push_write(dcsp_pkg::CFG_DEPTH_SCALE, 16'($urandom_range(0, 65535)));
      end
      n = int'($urandom_range(20, 90));
      for (int i = 0; i < n; i++) push_random_pixel();
      sent += n;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // checked mid-cycle so the driver's updates at the edge are all visible
    while (pixel_feed.size() != 0 || in_valid || span_expect_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
